[src/assert_macros.svh]
// Assertion helper macros shared by the framer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/mbrtu_pkg.sv]
// Shared types, codes and the CRC-16/MODBUS byte step for the RTU read framer.
// No dependencies.
`default_nettype none

package mbrtu_pkg;

    // Configuration defaults.
    localparam int MAX_REGISTERS_DEF = 125;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Input item types.
    localparam logic [1:0] REQ_SEND    = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // Result kinds.
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_BAD_FUNC = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // Protocol constants.
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  RESP_OVERHEAD     = 8'd5;
    localparam logic [7:0]  FUNC_BYTE_NUM     = 8'd2;
    localparam logic [2:0]  TX_LAST_IDX       = 3'd7;
    localparam logic [2:0]  TX_CRC_LO_IDX     = 3'd6;

    // Command queue entry kinds.
    localparam logic QK_SEND   = 1'b0;
    localparam logic QK_STATUS = 1'b1;

    // One command from the front part to the back part.
    typedef struct packed {
        logic        kind;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [6:0]  cnt;
        logic [1:0]  status;
        logic [7:0]  count;
    } q_entry_t;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One byte of CRC-16/MODBUS (reflected, LSB first).
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/mbrtu_if.sv]
// Channel interfaces of the RTU read framer: input items, results, configuration.
// Depends on nothing but the package-free payload widths given here.
`default_nettype none

interface mbrtu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] start_address;
    logic [6:0]  register_count;
    logic [7:0]  rx_byte;

    modport source (output valid, req_type, start_address, register_count, rx_byte,
                    input ready);
    modport sink (input valid, req_type, start_address, register_count, rx_byte,
                  output ready);
endinterface

interface mbrtu_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] frame_status;
    logic [7:0] bytes_received;

    modport source (output valid, out_kind, tx_byte, last, frame_status, bytes_received,
                    input ready);
    modport sink (input valid, out_kind, tx_byte, last, frame_status, bytes_received,
                  output ready);
endinterface

interface mbrtu_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[src/mbrtu_fifo.sv]
// Short command queue between the front and back parts of the framer.
// Depends on mbrtu_pkg for the entry and status types.
`default_nettype none

`include "assert_macros.svh"

module mbrtu_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mbrtu_pkg::q_entry_t push_data,
    input  wire logic               pop,
    output mbrtu_pkg::q_entry_t     head,
    output mbrtu_pkg::q_stat_t      stat
);
    import mbrtu_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    q_entry_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == FullCnt);
    assign stat.empty = (cnt_reg == '0);

    `ASSERT_IMP(a_fifo_count_range, 1'b1, cnt_reg <= FullCnt)
    `ASSERT_IMP(a_fifo_no_overflow, push, !stat.full || pop)

endmodule

`default_nettype wire

[src/mbrtu_front.sv]
// Front part of the framer: takes input items and configuration, tracks the
// response in progress and queues commands. Depends on mbrtu_pkg and mbrtu_if.
`default_nettype none

`include "assert_macros.svh"

module mbrtu_front #(
    parameter int MAX_REGISTERS = mbrtu_pkg::MAX_REGISTERS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mbrtu_req_if.sink           req,
    mbrtu_cfg_if.sink           cfg,
    input  wire mbrtu_pkg::q_stat_t q_stat,
    output logic                push,
    output mbrtu_pkg::q_entry_t push_data
);
    import mbrtu_pkg::*;

    localparam logic [6:0] MaxCnt = 7'(MAX_REGISTERS);

    logic [7:0]  slave_addr_reg, slave_addr_next;
    logic        await_reg, await_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;

    logic        accept;
    logic [6:0]  cnt_sat;
    logic [7:0]  idx_inc;
    logic [15:0] crc_upd;

    // The queue has room for whatever one item can need.
    assign req.ready = !q_stat.full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign cnt_sat = (req.register_count > MaxCnt) ? MaxCnt : req.register_count;
    assign idx_inc = idx_reg + 8'd1;
    assign crc_upd = crc16_update(crc_reg, req.rx_byte);

    // Configuration register.
    assign slave_addr_next = (cfg.valid && cfg.ready) ? cfg.data : slave_addr_reg;

    // Item classification and response tracking.
    always_comb
    begin
        await_next   = await_reg;
        exp_len_next = exp_len_reg;
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        push         = 1'b0;
        push_data    = '0;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_SEND:
                begin
                    push           = 1'b1;
                    push_data.kind = QK_SEND;
                    push_data.slave = slave_addr_reg;
                    push_data.addr = req.start_address;
                    push_data.cnt  = cnt_sat;
                    await_next     = 1'b1;
                    exp_len_next   = RESP_OVERHEAD + {cnt_sat, 1'b0};
                    idx_next       = '0;
                    crc_next       = CRC_INIT;
                end
                REQ_BYTE:
                begin
                    if (await_reg)
                    begin
                        crc_next = crc_upd;
                        idx_next = idx_inc;
                        priority if (idx_inc == FUNC_BYTE_NUM &&
                                     req.rx_byte != FUNC_READ_HOLDING)
                        begin
                            push             = 1'b1;
                            push_data.kind   = QK_STATUS;
                            push_data.status = ST_BAD_FUNC;
                            push_data.count  = idx_inc;
                            await_next       = 1'b0;
                            crc_next         = CRC_INIT;
                        end
                        else if (idx_inc >= exp_len_reg)
                        begin
                            push             = 1'b1;
                            push_data.kind   = QK_STATUS;
                            push_data.status = (crc_upd == '0) ? ST_OK : ST_CRC_ERR;
                            push_data.count  = idx_inc;
                            await_next       = 1'b0;
                            crc_next         = CRC_INIT;
                        end
                        else
                        begin
                            await_next = 1'b1;
                        end
                    end
                end
                REQ_TIMEOUT:
                begin
                    if (await_reg)
                    begin
                        push             = 1'b1;
                        push_data.kind   = QK_STATUS;
                        push_data.status = ST_TIMEOUT;
                        push_data.count  = idx_reg;
                        await_next       = 1'b0;
                        crc_next         = CRC_INIT;
                    end
                end
                default:
                begin
                    await_next = await_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            await_reg      <= 1'b0;
            exp_len_reg    <= '0;
            idx_reg        <= '0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
            await_reg      <= await_next;
            exp_len_reg    <= exp_len_next;
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
        end
    end

    `ASSERT_IMP(a_front_idx_below_len, await_reg, idx_reg < exp_len_reg)
    `ASSERT_IMP(a_front_status_needs_wait, push && push_data.kind == QK_STATUS, await_reg)

endmodule

`default_nettype wire

[src/mbrtu_back.sv]
// Back part of the framer: expands queued commands into result transactions
// through an output register. Depends on mbrtu_pkg and mbrtu_if.
`default_nettype none

`include "assert_macros.svh"

module mbrtu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mbrtu_pkg::q_entry_t head,
    input  wire mbrtu_pkg::q_stat_t  q_stat,
    output logic                     pop,
    mbrtu_res_if.source              res
);
    import mbrtu_pkg::*;

    logic       res_valid_reg, res_valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] tx_reg, tx_next;
    logic       last_reg, last_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] count_reg, count_next;
    logic [2:0] idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;

    logic        slot_free;
    logic        go;
    logic [7:0]  tx_val;
    logic [15:0] crc_base;

    assign slot_free = !res_valid_reg || res.ready;
    assign go        = slot_free && !q_stat.empty;

    // Request frame byte for the current position.
    always_comb
    begin
        unique case (idx_reg)
            3'd0:    tx_val = head.slave;
            3'd1:    tx_val = FUNC_READ_HOLDING;
            3'd2:    tx_val = head.addr[15:8];
            3'd3:    tx_val = head.addr[7:0];
            3'd4:    tx_val = 8'h00;
            3'd5:    tx_val = {1'b0, head.cnt};
            3'd6:    tx_val = crc_reg[7:0];
            3'd7:    tx_val = crc_reg[15:8];
            default: tx_val = 8'h00;
        endcase
    end

    assign crc_base = (idx_reg == '0) ? CRC_INIT : crc_reg;

    // Result sequencing.
    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        kind_next      = kind_reg;
        tx_next        = tx_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        pop            = 1'b0;
        if (go)
        begin
            res_valid_next = 1'b1;
            if (head.kind == QK_STATUS)
            begin
                kind_next   = KIND_STATUS;
                tx_next     = '0;
                last_next   = 1'b0;
                status_next = head.status;
                count_next  = head.count;
                pop         = 1'b1;
            end
            else
            begin
                kind_next   = KIND_TX;
                tx_next     = tx_val;
                last_next   = (idx_reg == TX_LAST_IDX);
                status_next = ST_OK;
                count_next  = '0;
                idx_next    = idx_reg + 3'd1;
                pop         = (idx_reg == TX_LAST_IDX);
                if (idx_reg < TX_CRC_LO_IDX)
                    crc_next = crc16_update(crc_base, tx_val);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Result payload and frame CRC; no reset needed.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        tx_reg     <= tx_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        crc_reg    <= crc_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.out_kind       = kind_reg;
    assign res.tx_byte        = tx_reg;
    assign res.last           = last_reg;
    assign res.frame_status   = status_reg;
    assign res.bytes_received = count_reg;

    `ASSERT_IMP(a_back_mid_frame_head, idx_reg != '0, !q_stat.empty && head.kind == QK_SEND)

endmodule

`default_nettype wire

[src/modbus_rtu_read_master_framer.sv]
// Top level of the Modbus RTU read-holding-registers master framer.
// Depends on mbrtu_pkg, mbrtu_if, mbrtu_front, mbrtu_fifo and mbrtu_back.
`default_nettype none

// The block takes one input item per cycle on req while the queue has room: a
// send request, a received response byte or a timeout. A send request yields
// eight transmit transactions on res (address, function 3, start address,
// count, CRC low then high, the last one flagged), and a response that ends
// (wrong function code in its second byte, timeout, or expected length
// reached) yields one status transaction. Received bytes and timeouts with no
// response pending give nothing. The front part classifies each item and keeps
// the running CRC; commands pass through a QUEUE_DEPTH-entry queue to the back
// part, which emits one result per cycle from its output register unless res
// stalls, so other items keep flowing in while a request holds the output,
// until the queue fills. The first result of an item passes through the queue
// and then the output register before it is valid on res. The slave address
// register (reset value 1) is written on cfg and is taken ready at all times.
module modbus_rtu_read_master_framer #(
    parameter int MAX_REGISTERS = mbrtu_pkg::MAX_REGISTERS_DEF,
    parameter int QUEUE_DEPTH   = mbrtu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mbrtu_cfg_if.sink   cfg,
    mbrtu_req_if.sink   req,
    mbrtu_res_if.source res
);
    import mbrtu_pkg::*;

    q_entry_t push_data;
    q_entry_t head;
    q_stat_t  q_stat;
    logic     push;
    logic     pop;

    // Item classification and response tracking.
    mbrtu_front #(
        .MAX_REGISTERS(MAX_REGISTERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_data(push_data)
    );

    // Command queue between the two parts.
    mbrtu_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // Result generation.
    mbrtu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .q_stat(q_stat),
        .pop   (pop),
        .res   (res)
    );

endmodule

`default_nettype wire

[dv/modbus_rtu_read_master_framer_tb.sv]
// Self-checking testbench for the Modbus RTU read-holding-registers master framer.
// Depends on mbrtu_pkg, the channel interfaces in mbrtu_if and the framer RTL.
`timescale 1ns / 100ps

module modbus_rtu_read_master_framer_tb;

    import mbrtu_pkg::*;

    // The unused request code, which the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int MAX_REGS      = MAX_REGISTERS_DEF;
    localparam int ITEM_BUDGET   = 160;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    // Shapes of a slave response fed back to the block.
    typedef enum int {
        RESP_GOOD,
        RESP_BAD_CRC,
        RESP_BAD_FUNC,
        RESP_CUT_TIMEOUT,
        RESP_CUT_OPEN
    } resp_shape_e;

    // One result transaction as seen on the result channel.
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] status;
        logic [7:0] nbytes;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mbrtu_cfg_if cfg_ch ();
    mbrtu_req_if req_ch ();
    mbrtu_res_if res_ch ();

    modbus_rtu_read_master_framer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Shadow of the block's register and response tracking state.
    logic [7:0]  slave_addr_q;
    logic        awaiting;
    logic [7:0]  exp_len;
    logic [7:0]  rx_count;
    logic [15:0] resp_crc;

    frame_result_t pending_results[$];
    frame_result_t seen_result;
    frame_result_t want_result;

    int error_count     = 0;
    int items_sent      = 0;
    int hold_left       = 0;
    bit idle_on         = 1'b1;
    bit stall_on        = 1'b1;

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One byte step of the reflected CRC-16 used by Modbus RTU.
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc_in,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Register counts above the limit are saturated to the limit.
    function automatic logic [6:0] clamp_count(input logic [6:0] c);
        return (c > MAX_REGS) ? 7'(MAX_REGS) : c;
    endfunction

    // Appends one expected result transaction at the tail of the queue.
    function automatic void queue_result(input frame_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Ends the pending response and queues its status transaction.
    function automatic void close_frame(input logic [1:0] status);
        queue_result('{KIND_STATUS, 8'h00, 1'b0, status, rx_count});
        awaiting = 1'b0;
        resp_crc = CRC_INIT;
    endfunction

    // Works out the results of one accepted input item and updates the shadow state.
    function automatic void predict_item(input logic [1:0]  kind,
                                         input logic [15:0] addr,
                                         input logic [6:0]  cnt_in,
                                         input logic [7:0]  rx);
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic [6:0]  cnt;
        case (kind)
            REQ_SEND:
            begin
                cnt = clamp_count(cnt_in);
                frame[0] = slave_addr_q;
                frame[1] = FUNC_READ_HOLDING;
                frame[2] = addr[15:8];
                frame[3] = addr[7:0];
                frame[4] = 8'h00;
                frame[5] = {1'b0, cnt};
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++)
                    crc = modbus_crc_step(crc, frame[i]);
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                for (int i = 0; i < 8; i++)
                    queue_result('{KIND_TX, frame[i], (i == 7), ST_OK, 8'd0});
                awaiting = 1'b1;
                exp_len  = RESP_OVERHEAD + {cnt, 1'b0};
                rx_count = 8'd0;
                resp_crc = CRC_INIT;
            end
            REQ_BYTE:
            begin
                if (awaiting)
                begin
                    resp_crc = modbus_crc_step(resp_crc, rx);
                    rx_count = rx_count + 8'd1;
                    if (rx_count == FUNC_BYTE_NUM && rx != FUNC_READ_HOLDING)
                        close_frame(ST_BAD_FUNC);
                    else if (rx_count >= exp_len)
                        close_frame((resp_crc == 16'h0000) ? ST_OK : ST_CRC_ERR);
                end
            end
            REQ_TIMEOUT:
            begin
                if (awaiting)
                    close_frame(ST_TIMEOUT);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offers one input item, with an occasional gap first, and waits for its transaction.
    task automatic send_item(input logic [1:0]  kind,
                             input logic [15:0] addr,
                             input logic [6:0]  cnt,
                             input logic [7:0]  rx);
        if (idle_on && $urandom_range(99) < 20)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.start_address  <= addr;
        req_ch.register_count <= cnt;
        req_ch.rx_byte        <= rx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        predict_item(kind, addr, cnt, rx);
    endtask

    // Feeds back a slave response for a request of the given count, shaped as asked.
    task automatic send_response(input logic [6:0] cnt_raw, input resp_shape_e shape);
        logic [7:0]  frame_bytes [$];
        logic [15:0] crc;
        logic [7:0]  bad;
        int          cnt;
        int          cut;
        int          pos;
        cnt = int'(clamp_count(cnt_raw));
        frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 247)));
        frame_bytes.insert(frame_bytes.size(), FUNC_READ_HOLDING);
        frame_bytes.insert(frame_bytes.size(), 8'(2 * cnt));
        repeat (2 * cnt)
            frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        crc = CRC_INIT;
        foreach (frame_bytes[i])
            crc = modbus_crc_step(crc, frame_bytes[i]);
        frame_bytes.insert(frame_bytes.size(), crc[7:0]);
        frame_bytes.insert(frame_bytes.size(), crc[15:8]);
        cut = frame_bytes.size();
        case (shape)
            RESP_BAD_CRC:
            begin
                pos = $urandom_range(0, cut - 1);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            RESP_BAD_FUNC:
            begin
                do
                    bad = 8'($urandom);
                while (bad == FUNC_READ_HOLDING);
                frame_bytes[1] = bad;
                cut = 2;
            end
            RESP_CUT_TIMEOUT, RESP_CUT_OPEN:
                cut = $urandom_range(0, cut - 1);
            default:
            begin
            end
        endcase
        for (int i = 0; i < cut; i++)
            send_item(REQ_BYTE, 16'($urandom), 7'($urandom), frame_bytes[i]);
        if (shape == RESP_CUT_TIMEOUT)
            send_item(REQ_TIMEOUT, 16'($urandom), 7'($urandom), 8'($urandom));
    endtask

    // Stops offering items and waits until every expected result has come out.
    task automatic settle_block();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the slave address register once the block is quiet.
    task automatic write_slave_address(input logic [7:0] value);
        settle_block();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        slave_addr_q = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly small counts, now and then a mid-size one.
    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 90)
            return 7'($urandom_range(0, 4));
        else
            return 7'($urandom_range(5, 12));
    endfunction

    // Field extremes, every item type and the protocol corner cases.
    task automatic test_directed_cases();
        // Bytes, timeouts and the unused code with nothing pending.
        send_item(REQ_BYTE, 16'hFFFF, 7'h7F, 8'hFF);
        send_item(REQ_TIMEOUT, 16'h0000, 7'h00, 8'h00);
        send_item(REQ_UNUSED, 16'hA5A5, 7'h55, 8'h5A);

        // Zero count at the lowest address, answered by a correct five-byte frame.
        send_item(REQ_SEND, 16'h0000, 7'd0, 8'h00);
        send_response(7'd0, RESP_GOOD);

        // Count above the limit, then a new request while that one is pending.
        send_item(REQ_SEND, 16'hFFFF, 7'd127, 8'hFF);
        send_item(REQ_SEND, 16'h1234, 7'd2, 8'h00);
        send_response(7'd2, RESP_BAD_FUNC);

        // One byte taken, an ignored unused code, then a timeout.
        send_item(REQ_SEND, 16'h00FF, 7'd126, 8'h00);
        send_item(REQ_BYTE, 16'h0000, 7'h00, 8'h11);
        send_item(REQ_UNUSED, 16'h0000, 7'h00, 8'h00);
        send_item(REQ_TIMEOUT, 16'hFFFF, 7'h7F, 8'hFF);

        // A one-register response with a damaged byte.
        send_item(REQ_SEND, 16'h8000, 7'd1, 8'h00);
        send_response(7'd1, RESP_BAD_CRC);

        // Timeout before any response byte.
        send_item(REQ_SEND, 16'h7FFF, 7'd125, 8'h00);
        send_item(REQ_TIMEOUT, 16'h0000, 7'h00, 8'h00);
    endtask

    // Slave address at both ends of its range and in between.
    task automatic test_slave_address_settings();
        logic [7:0] values [4];
        values[0] = 8'd0;
        values[1] = 8'd247;
        values[2] = 8'($urandom_range(2, 246));
        values[3] = 8'd1;
        foreach (values[i])
        begin
            write_slave_address(values[i]);
            send_item(REQ_SEND, 16'($urandom), 7'($urandom_range(0, 3)), 8'h00);
            send_response(req_ch.register_count, RESP_GOOD);
        end
    endtask

    // The receiver holds off while requests keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        settle_block();
        idle_on = 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (4)
            send_item(REQ_SEND, 16'($urandom), 7'($urandom_range(0, 3)), 8'($urandom));
        send_response(req_ch.register_count, RESP_GOOD);
        idle_on = 1'b1;
    endtask

    // Mostly request and response exchanges of random shape and content, the rest noise.
    task automatic test_random_traffic();
        logic [6:0]  cnt;
        int          shape_pick;
        resp_shape_e shape;
        int          start_at;
        int          done;
        int          next_cfg_at;
        start_at    = items_sent;
        next_cfg_at = 30;
        while (items_sent < ITEM_BUDGET)
        begin
            done = items_sent - start_at;

            // A stretch in the middle runs with no gaps on either side.
            idle_on  = !(done >= 20 && done < 50);
            stall_on = idle_on;

            if (done >= next_cfg_at)
            begin
                write_slave_address(8'($urandom_range(0, 247)));
                next_cfg_at = next_cfg_at + 30;
            end

            if ($urandom_range(99) < 75)
            begin
                cnt = pick_count();
                send_item(REQ_SEND, 16'($urandom), cnt, 8'($urandom));
                shape_pick = $urandom_range(99);
                if (shape_pick < 50)
                    shape = RESP_GOOD;
                else if (shape_pick < 65)
                    shape = RESP_BAD_CRC;
                else if (shape_pick < 75)
                    shape = RESP_BAD_FUNC;
                else if (shape_pick < 90)
                    shape = RESP_CUT_TIMEOUT;
                else
                    shape = RESP_CUT_OPEN;
                send_response(cnt, shape);
            end
            else
            begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom), 7'($urandom),
                          8'($urandom));
            end
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            res_ch.ready <= !(stall_on && $urandom_range(99) < 20);
    end

    // Each result transaction is compared with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen_result = '{res_ch.out_kind, res_ch.tx_byte, res_ch.last,
                            res_ch.frame_status, res_ch.bytes_received};
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result kind=%0d tx=%02h last=%0d status=%0d count=%0d",
                         $time, seen_result.kind, seen_result.tx_byte, seen_result.last,
                         seen_result.status, seen_result.nbytes);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected kind=%0d tx=%02h last=%0d status=%0d count=%0d",
                             $time, want_result.kind, want_result.tx_byte, want_result.last,
                             want_result.status, want_result.nbytes);
                    $display("%0t:           actual kind=%0d tx=%02h last=%0d status=%0d count=%0d",
                             $time, seen_result.kind, seen_result.tx_byte, seen_result.last,
                             seen_result.status, seen_result.nbytes);
                end
            end
        end
    end

    // Main sequence: reset, the tests in turn, then drain and report.
    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_SEND;
        req_ch.start_address  = 16'h0000;
        req_ch.register_count = 7'd0;
        req_ch.rx_byte        = 8'h00;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = 8'h00;
        res_ch.ready          = 1'b0;

        slave_addr_q = 8'd1;
        awaiting     = 1'b0;
        exp_len      = 8'd0;
        rx_count     = 8'd0;
        resp_crc     = CRC_INIT;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_slave_address_settings();
        test_output_backpressure();
        test_random_traffic();
        settle_block();

        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/mbrtu_pkg.sv
src/mbrtu_if.sv
src/mbrtu_fifo.sv
src/mbrtu_front.sv
src/mbrtu_back.sv
src/modbus_rtu_read_master_framer.sv
dv/modbus_rtu_read_master_framer_tb.sv
